@@ hw/rtl/efr_pkg.sv @@
// Shared definitions for the escaped frame receiver: framing codes, widths,
// the frame-match record passed from reception to readout, and the unescape map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

    // Framing codes on the wire
    localparam logic [7:0] HEAD_CODE = 8'hFD;
    localparam logic [7:0] ESC_CODE  = 8'hFE;
    localparam logic [7:0] TAIL_CODE = 8'hF8;

    // Escaped forms following ESC_CODE
    localparam logic [7:0] ESC_HEAD_CODE = 8'h7D;
    localparam logic [7:0] ESC_TAIL_CODE = 8'h78;
    localparam logic [7:0] ESC_ESC_CODE  = 8'h7E;

    // Head, type, serial, checksum and tail around the payload
    localparam int unsigned OVERHEAD = 5;

    localparam int unsigned FRAME_DEPTH_DEF = 64;
    localparam int unsigned SLOT_COUNT_DEF  = 3;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 6;
    localparam int unsigned SLOT_W  = 2;
    localparam int unsigned CFG_AW  = 3;
    localparam int unsigned CFG_DW  = 8;

    // Register map: two registers per slot, type then length
    localparam int unsigned CFG_STRIDE   = 2;
    localparam int unsigned CFG_TYPE_OFS = 0;
    localparam int unsigned CFG_LEN_OFS  = 1;

    // Result of a tail that matched a slot
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] serial;
        logic              cks_ok;
    } match_t;

    // Byte that follows an escape
    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            ESC_HEAD_CODE: r = HEAD_CODE;
            ESC_TAIL_CODE: r = TAIL_CODE;
            ESC_ESC_CODE:  r = ESC_CODE;
            default:       r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/escaped_frame_receiver_core.sv @@
// Escaped frame receiver top level: configuration registers, receive side,
// frame store and readout. Depends on efr_pkg, efr_rx, efr_store, efr_tx.
//
// Usage:
//  s_ channel: one raw link byte per beat in s_tdata[7:0]. While receiving,
//  s_tready is high and a byte is taken every cycle. Frames are
//  0xFD type payload serial checksum 0xF8, byte stuffed with 0xFE.
//  m_ channel: after a tail whose type and length match a slot, one beat per
//  payload byte (or a single marker beat with byte_valid low for an empty
//  payload), tlast on the final one. Frames that match nothing vanish.
//  Readout: after a matched tail the first result beat follows the store read
//  and output load, or comes straight from the match for an empty payload. Each
//  payload beat takes a store read, an output load and a handover, plus any stall
//  while m_tready is held low; the store has one read port, so that sequence sets the rate.
//  s_tready is low from the cycle after a matched tail until its last beat is taken.
//  Stall: a low m_tready holds the current beat and the readout; input stays
//  held off meanwhile. Nothing is dropped.
//  Reset: aresetn low for one clock clears the frame state, the readout and
//  the slot registers; the store contents need no clearing.
//  Configuration: cfg_wr_en/cfg_addr/cfg_wdata, write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_receiver_core #(
    parameter int unsigned FRAME_DEPTH = efr_pkg::FRAME_DEPTH_DEF,
    parameter int unsigned SLOT_COUNT  = efr_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration write port
    input  wire logic                         cfg_wr_en,
    input  wire logic [efr_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [efr_pkg::CFG_DW-1:0]   cfg_wdata,
    // link bytes
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] rx_byte
    // result beats
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [15:0]                       m_tdata,   // [7:0] frame_serial, [15:8] payload_byte
    output logic [3:0]                        m_tuser,   // [1:0] slot_index, [2] checksum_ok, [3] byte_valid
    output logic                              m_tlast    // last
);
    import efr_pkg::*;

    localparam int unsigned AW = $clog2(FRAME_DEPTH);

    logic [SLOT_COUNT-1:0][7:0] slot_type_reg;
    logic [SLOT_COUNT-1:0][5:0] slot_len_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          busy;
    match_t        match;

    // slot registers: two per slot, type then length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_type_reg <= '0;
            slot_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            for (int i = 0; i < int'(SLOT_COUNT); i++) begin
                if (cfg_addr == CFG_AW'(CFG_STRIDE * i + CFG_TYPE_OFS)) begin
                    slot_type_reg[i] <= cfg_wdata;
                end
                if (cfg_addr == CFG_AW'(CFG_STRIDE * i + CFG_LEN_OFS)) begin
                    slot_len_reg[i] <= cfg_wdata[LEN_W-1:0];
                end
            end
        end
    end

    assign s_tready = !busy;

    efr_rx #(
        .DEPTH      (FRAME_DEPTH),
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (s_tvalid && s_tready),
        .byte_in   (s_tdata),
        .slot_type (slot_type_reg),
        .slot_len  (slot_len_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .match     (match)
    );

    efr_store #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    efr_tx #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW)
    ) u_tx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .match    (match),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ hw/rtl/efr_store.sv @@
// Frame byte store: single write port, single read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module efr_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/efr_rx.sv @@
// Receive side: unescaping, frame tracking, store writes, running checksum
// and slot matching at the tail. Depends on efr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efr_rx #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned SLOT_COUNT = 3,
    parameter int unsigned AW         = $clog2(DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        byte_en,
    input  wire logic [7:0]                  byte_in,
    input  wire logic [SLOT_COUNT-1:0][7:0]  slot_type,
    input  wire logic [SLOT_COUNT-1:0][5:0]  slot_len,
    output logic                             wr_en,
    output logic [AW-1:0]                    wr_addr,
    output logic [7:0]                       wr_data,
    output efr_pkg::match_t                  match
);
    import efr_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned MW = (CW > 7) ? CW : 7;

    logic          in_frame_reg, in_frame_next;
    logic          esc_reg, esc_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    prev1_reg, prev1_next;
    logic [7:0]    prev2_reg, prev2_next;
    logic [7:0]    type_reg, type_next;
    match_t        match_reg, match_next;

    logic          store;
    logic          is_tail;
    logic [7:0]    data;
    logic [7:0]    sum_final;
    logic [MW-1:0] frame_len;

    // classify the incoming byte
    always_comb begin
        store   = 1'b0;
        is_tail = 1'b0;
        data    = byte_in;
        if (byte_en) begin
            if (byte_in == HEAD_CODE) begin
                store = 1'b1;
            end else if (in_frame_reg) begin
                if (esc_reg) begin
                    data  = unescape(byte_in);
                    store = 1'b1;
                end else if (byte_in != ESC_CODE) begin
                    store   = 1'b1;
                    is_tail = (byte_in == TAIL_CODE);
                end
            end
        end
    end

    // checksum covers type to serial; the last two stored bytes lag behind
    assign sum_final = sum_reg + prev2_reg;
    assign frame_len = MW'(fill_reg) + MW'(1);

    // frame state update
    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        prev1_next    = prev1_reg;
        prev2_next    = prev2_reg;
        type_next     = type_reg;
        match_next    = '0;
        wr_en         = 1'b0;
        wr_addr       = fill_reg[AW-1:0];
        wr_data       = data;

        if (byte_en && byte_in == HEAD_CODE) begin
            // head always restarts and is stored at entry zero
            in_frame_next = 1'b1;
            esc_next      = 1'b0;
            fill_next     = CW'(1);
            sum_next      = '0;
            prev1_next    = byte_in;
            wr_en         = 1'b1;
            wr_addr       = '0;
        end else if (byte_en && in_frame_reg && !esc_reg && byte_in == ESC_CODE) begin
            esc_next = 1'b1;
        end else if (store) begin
            esc_next = 1'b0;
            if (fill_reg >= CW'(DEPTH)) begin
                // overflow: discard the frame
                in_frame_next = 1'b0;
                fill_next     = '0;
            end else begin
                wr_en      = 1'b1;
                fill_next  = fill_reg + CW'(1);
                prev1_next = data;
                prev2_next = prev1_reg;
                if (fill_reg >= CW'(3)) begin
                    sum_next = sum_final;
                end
                if (fill_reg == CW'(1)) begin
                    type_next = data;
                end
                if (is_tail) begin
                    in_frame_next = 1'b0;
                    fill_next     = '0;
                    // last matching slot wins
                    for (int i = 0; i < int'(SLOT_COUNT); i++) begin
                        if (type_reg == slot_type[i] &&
                            frame_len == MW'(slot_len[i]) + MW'(OVERHEAD)) begin
                            match_next.valid = 1'b1;
                            match_next.slot  = SLOT_W'(i);
                            match_next.len   = slot_len[i];
                        end
                    end
                    match_next.serial = prev2_reg;
                    match_next.cks_ok = (sum_final == prev1_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            fill_reg     <= '0;
            match_reg    <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            fill_reg     <= fill_next;
            match_reg    <= match_next;
        end
    end

    // data path registers
    always_ff @(posedge aclk) begin
        sum_reg   <= sum_next;
        prev1_reg <= prev1_next;
        prev2_reg <= prev2_next;
        type_reg  <= type_next;
    end

    assign match = match_reg;

endmodule

`default_nettype wire

@@ hw/rtl/efr_tx.sv @@
// Readout sequencer: walks the stored payload of a matched frame and drives
// the result beats from an output register. Depends on efr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efr_tx #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire efr_pkg::match_t match,
    output logic                 busy,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  wire logic [7:0]      rd_data,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [15:0]          m_tdata,
    output logic [3:0]           m_tuser,
    output logic                 m_tlast
);
    import efr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t            state_reg;
    logic [LEN_W-1:0]  ptr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [7:0]        serial_reg;
    logic              ok_reg;
    logic              valid_reg;
    logic              last_reg;
    logic              bvalid_reg;
    logic [7:0]        payload_reg;

    assign busy    = (state_reg != ST_IDLE) || match.valid;
    assign rd_en   = (state_reg == ST_READ);
    assign rd_addr = AW'(ptr_reg) + AW'(2);

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            ptr_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (match.valid) begin
                        slot_reg   <= match.slot;
                        serial_reg <= match.serial;
                        ok_reg     <= match.cks_ok;
                        len_reg    <= match.len;
                        ptr_reg    <= '0;
                        if (match.len == '0) begin
                            // empty payload: one marker beat
                            valid_reg   <= 1'b1;
                            bvalid_reg  <= 1'b0;
                            payload_reg <= '0;
                            last_reg    <= 1'b1;
                            state_reg   <= ST_SEND;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    valid_reg   <= 1'b1;
                    bvalid_reg  <= 1'b1;
                    payload_reg <= rd_data;
                    last_reg    <= (ptr_reg + LEN_W'(1) == len_reg);
                    state_reg   <= ST_SEND;
                end
                ST_SEND: begin
                    if (m_tready) begin
                        valid_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            ptr_reg   <= ptr_reg + LEN_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {payload_reg, serial_reg};
    assign m_tuser  = {bvalid_reg, ok_reg, slot_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/efr_checker.sv @@
// Port-level checks for the escaped frame receiver, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module efr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [3:0]  m_tuser,
    input wire logic        m_tlast
);

    // input is held off while a result beat is offered
    a_no_rx_during_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result beat is pending");

    // readout continues after a non-final beat
    a_readout_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("input reopened in the middle of a frame readout");

    // empty-payload marker is always a final beat with a zero payload byte
    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[3] |-> m_tlast && m_tdata[15:8] == 8'h00)
        else $error("empty payload marker not a lone final beat");

    // a slot index never names the unused code
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1:0] != 2'd3)
        else $error("slot index out of range");

    // stalled beat holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

endmodule

bind escaped_frame_receiver_core efr_checker u_efr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ test/tb_escaped_frame_receiver_core.sv @@
// Self-checking testbench for escaped_frame_receiver_core: drives link bytes,
// predicts the payload beats of each matched frame and checks them on m_.
// Depends on efr_pkg and escaped_frame_receiver_core.
`timescale 1ns / 1ps

module tb_escaped_frame_receiver_core;

    import efr_pkg::*;

    // One expected payload beat
    typedef struct packed {
        logic [1:0] slot;
        logic [7:0] serial;
        logic       cks_ok;
        logic       byte_valid;
        logic [7:0] payload;
        logic       last;
    } payload_beat_t;

    localparam int unsigned    STORE_DEPTH  = FRAME_DEPTH_DEF;
    localparam int unsigned    NUM_SLOTS    = SLOT_COUNT_DEF;
    localparam int unsigned    MAX_LEN      = 59;
    localparam logic [2:0]     CFG_SPARE_LO = 3'd6;
    localparam logic [2:0]     CFG_SPARE_HI = 3'd7;
    localparam int unsigned    LONG_HOLD    = 250;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // [7:0] frame_serial, [15:8] payload_byte
    logic [3:0]  m_tuser;      // [1:0] slot_index, [2] checksum_ok, [3] byte_valid
    logic        m_tlast;

    escaped_frame_receiver_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Deframer shadow: store, fill level, framing flags and slot registers
    logic [7:0]    shadow_store [STORE_DEPTH];
    int unsigned   shadow_fill;
    bit            shadow_in_frame;
    bit            shadow_esc;
    logic [7:0]    slot_type_q [NUM_SLOTS];
    logic [5:0]    slot_len_q  [NUM_SLOTS];

    payload_beat_t payload_beats_due[$];
    logic [7:0]    link_q[$];         // raw bytes waiting to go out
    logic [7:0]    frame_payload[$];  // unescaped payload of the next frame

    int  error_count  = 0;
    int  bytes_sent   = 0;
    int  beats_seen   = 0;
    bit  tx_gaps_on   = 1'b1;
    bit  rx_stalls_on = 1'b1;
    bit  long_hold_req = 1'b0;

    // Clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Safety net
    initial begin
        #2_000_000;
        $display("FAIL escaped_frame_receiver_core");
        $finish;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    task automatic drop_shadow_frame();
        shadow_fill     = 0;
        shadow_in_frame = 1'b0;
        shadow_esc      = 1'b0;
    endtask

    // Tail seen: find the winning slot and queue the payload beats
    task automatic close_frame();
        int            chosen;
        int unsigned   n;
        int unsigned   len;
        logic [7:0]    sum;
        logic [7:0]    serial;
        logic          ok;
        payload_beat_t pb;
        n      = shadow_fill;
        chosen = -1;
        if (n >= 2) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (shadow_store[1] == slot_type_q[i] && n == slot_len_q[i] + OVERHEAD)
                    chosen = i;
            end
        end
        if (chosen >= 0) begin
            len = slot_len_q[chosen];
            sum = 8'h00;
            for (int unsigned i = 1; i + 2 < n; i++)
                sum = sum + shadow_store[i];
            serial = shadow_store[2 + len];
            ok     = (sum == shadow_store[3 + len]);
            pb.slot   = 2'(chosen);
            pb.serial = serial;
            pb.cks_ok = ok;
            if (len == 0) begin
                // empty payload: one marker beat
                pb.byte_valid = 1'b0;
                pb.payload    = 8'h00;
                pb.last       = 1'b1;
                payload_beats_due.push_back(pb);
            end else begin
                for (int unsigned k = 0; k < len; k++) begin
                    pb.byte_valid = 1'b1;
                    pb.payload    = shadow_store[2 + k];
                    pb.last       = (k + 1 == len);
                    payload_beats_due.push_back(pb);
                end
            end
        end
        drop_shadow_frame();
    endtask

    // One accepted link byte
    task automatic deframe_byte(input logic [7:0] raw);
        logic [7:0] b;
        bit         is_tail;
        b       = raw;
        is_tail = 1'b0;
        if (raw == HEAD_CODE) begin
            drop_shadow_frame();
            shadow_in_frame = 1'b1;
        end else if (!shadow_in_frame) begin
            return;
        end
        if (shadow_esc) begin
            case (raw)
                ESC_HEAD_CODE: b = HEAD_CODE;
                ESC_TAIL_CODE: b = TAIL_CODE;
                ESC_ESC_CODE:  b = ESC_CODE;
                default:       b = raw;
            endcase
            shadow_esc = 1'b0;
        end else if (raw == ESC_CODE) begin
            shadow_esc = 1'b1;
            return;
        end else if (raw == TAIL_CODE) begin
            is_tail = 1'b1;
        end
        // overlong frame is thrown away
        if (shadow_fill >= STORE_DEPTH) begin
            drop_shadow_frame();
            return;
        end
        shadow_store[shadow_fill] = b;
        shadow_fill++;
        if (is_tail)
            close_frame();
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        payload_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (payload_beats_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual data %h user %h last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                error_count++;
            end else begin
                want = payload_beats_due.pop_front();
                check_field("slot_index",   want.slot,       m_tuser[1:0]);
                check_field("checksum_ok",  want.cks_ok,     m_tuser[2]);
                check_field("byte_valid",   want.byte_valid, m_tuser[3]);
                check_field("frame_serial", want.serial,     m_tdata[7:0]);
                check_field("payload_byte", want.payload,    m_tdata[15:8]);
                check_field("last",         want.last,       m_tlast);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Link side helpers
    // ---------------------------------------------------------------

    // Offer one byte and wait for the beat to be taken
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic send_link();
        while (link_q.size() != 0)
            send_byte(link_q.pop_front());
    endtask

    // Wait for the block to go quiet before touching the registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (payload_beats_due.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_slot_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx < NUM_SLOTS * CFG_STRIDE) begin
            if (idx % CFG_STRIDE == CFG_TYPE_OFS)
                slot_type_q[idx / CFG_STRIDE] = val;
            else
                slot_len_q[idx / CFG_STRIDE] = val[5:0];
        end
    endtask

    task automatic set_slots(input logic [7:0] t0, input logic [7:0] l0,
                             input logic [7:0] t1, input logic [7:0] l1,
                             input logic [7:0] t2, input logic [7:0] l2);
        settle();
        write_slot_reg(3'(0 * CFG_STRIDE + CFG_TYPE_OFS), t0);
        write_slot_reg(3'(0 * CFG_STRIDE + CFG_LEN_OFS),  l0);
        write_slot_reg(3'(1 * CFG_STRIDE + CFG_TYPE_OFS), t1);
        write_slot_reg(3'(1 * CFG_STRIDE + CFG_LEN_OFS),  l1);
        write_slot_reg(3'(2 * CFG_STRIDE + CFG_TYPE_OFS), t2);
        write_slot_reg(3'(2 * CFG_STRIDE + CFG_LEN_OFS),  l2);
    endtask

    // Byte stuffing, with the odd harmless escape and the raw-tail escape form
    task automatic stuff_byte(input logic [7:0] b);
        case (b)
            HEAD_CODE: begin
                link_q.push_back(ESC_CODE);
                link_q.push_back(ESC_HEAD_CODE);
            end
            ESC_CODE: begin
                link_q.push_back(ESC_CODE);
                link_q.push_back(ESC_ESC_CODE);
            end
            TAIL_CODE: begin
                link_q.push_back(ESC_CODE);
                link_q.push_back($urandom_range(0, 1) ? ESC_TAIL_CODE : TAIL_CODE);
            end
            ESC_HEAD_CODE, ESC_TAIL_CODE, ESC_ESC_CODE: link_q.push_back(b);
            default: begin
                if ($urandom_range(0, 15) == 0)
                    link_q.push_back(ESC_CODE);
                link_q.push_back(b);
            end
        endcase
    endtask

    task automatic fill_payload(input int n);
        logic [7:0] specials [8];
        specials = '{HEAD_CODE, TAIL_CODE, ESC_CODE, ESC_HEAD_CODE,
                     ESC_TAIL_CODE, ESC_ESC_CODE, 8'h00, 8'hFF};
        frame_payload.delete();
        repeat (n) begin
            if ($urandom_range(0, 5) == 0)
                frame_payload.push_back(specials[$urandom_range(0, 7)]);
            else
                frame_payload.push_back(8'($urandom));
        end
    endtask

    // Whole frame around frame_payload; a bad checksum if asked
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] serial,
                              input bit bad_cks);
        logic [7:0] sum;
        sum = ftype + serial;
        foreach (frame_payload[i])
            sum = sum + frame_payload[i];
        if (bad_cks)
            sum = sum ^ 8'($urandom_range(1, 255));
        link_q.push_back(HEAD_CODE);
        stuff_byte(ftype);
        foreach (frame_payload[i])
            stuff_byte(frame_payload[i]);
        stuff_byte(serial);
        stuff_byte(sum);
        link_q.push_back(TAIL_CODE);
        send_link();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // All slots at reset: type 0, length 0, so a bare frame lands on slot 2
    task automatic test_reset_slots();
        frame_payload.delete();
        send_frame(8'h00, 8'h81, 1'b0);
        frame_payload.delete();
        send_frame(8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_directed_frames();
        set_slots(8'h00, 8'd8, 8'h5A, 8'd1, 8'hFF, 8'(MAX_LEN));
        // bytes outside a frame, an escape among them, are ignored
        link_q = '{8'h00, TAIL_CODE, ESC_CODE, ESC_HEAD_CODE, 8'hFF};
        send_link();
        frame_payload = '{8'h33};
        send_frame(8'h5A, 8'h01, 1'b0);
        // every framing code in the payload, plus the byte extremes
        frame_payload = '{HEAD_CODE, TAIL_CODE, ESC_CODE, ESC_HEAD_CODE,
                          ESC_TAIL_CODE, ESC_ESC_CODE, 8'h00, 8'hFF};
        send_frame(8'h00, HEAD_CODE, 1'b0);
        // escape before a raw tail value keeps it as data
        link_q = '{HEAD_CODE, 8'h5A, ESC_CODE, TAIL_CODE, 8'h3C, 8'h8E, TAIL_CODE};
        send_link();
        // escape before an ordinary byte passes it through
        link_q = '{HEAD_CODE, 8'h5A, ESC_CODE, 8'h41, 8'h3C, 8'hD7, TAIL_CODE};
        send_link();
        // head in mid-frame restarts, also straight after an escape
        link_q = '{HEAD_CODE, 8'h5A, 8'h12, 8'h34, HEAD_CODE, 8'h5A, 8'h77, 8'h3C,
                   8'h0D, TAIL_CODE};
        send_link();
        link_q = '{HEAD_CODE, 8'h5A, ESC_CODE, HEAD_CODE, 8'h5A, 8'h22, 8'h3C,
                   8'hB8, TAIL_CODE};
        send_link();
        // bad checksum still comes out, flagged
        frame_payload = '{8'h99};
        send_frame(8'h5A, 8'h02, 1'b1);
        // wrong length, then wrong type: both vanish
        frame_payload = '{8'h10, 8'h20};
        send_frame(8'h5A, 8'h03, 1'b0);
        frame_payload = '{8'h10};
        send_frame(8'h11, 8'h04, 1'b0);
        // short frames
        link_q = '{HEAD_CODE, TAIL_CODE, HEAD_CODE, 8'h00, TAIL_CODE};
        send_link();
        // longest payload on the all-ones type
        fill_payload(MAX_LEN);
        frame_payload[0] = 8'h00;
        frame_payload[1] = 8'hFF;
        send_frame(8'hFF, 8'h00, 1'b0);
        // overlong frame is discarded and the tail after it ignored
        link_q.push_back(HEAD_CODE);
        repeat (STORE_DEPTH + 2) link_q.push_back(8'h20);
        link_q.push_back(TAIL_CODE);
        link_q.push_back(8'h5A);
        send_link();
        frame_payload = '{8'h44};
        send_frame(8'h5A, 8'hFF, 1'b0);
    endtask

    // Hold the result side off while frames keep coming
    task automatic test_input_backpressure();
        tx_gaps_on    = 1'b0;
        long_hold_req = 1'b1;
        fill_payload(8);
        send_frame(8'h00, 8'h55, 1'b0);
        frame_payload = '{8'h66};
        send_frame(8'h5A, 8'hAA, 1'b0);
        fill_payload(8);
        send_frame(8'h00, 8'h56, 1'b0);
        tx_gaps_on = 1'b1;
    endtask

    // Link goes silent until everything is out, then resumes
    task automatic test_drain_pause();
        fill_payload(8);
        send_frame(8'h00, 8'h10, 1'b0);
        s_tvalid <= 1'b0;
        while (payload_beats_due.size() != 0) @(posedge aclk);
        frame_payload = '{8'h77};
        send_frame(8'h5A, 8'h11, 1'b0);
    endtask

    // Overlapping slots: the higher one wins; spare indexes do nothing
    task automatic test_slot_priority();
        set_slots(HEAD_CODE, 8'd2, HEAD_CODE, 8'hC2, TAIL_CODE, 8'd0);
        write_slot_reg(CFG_SPARE_LO, 8'hFF);
        write_slot_reg(CFG_SPARE_HI, 8'h00);
        frame_payload = '{8'hA1, 8'hB2};
        send_frame(HEAD_CODE, ESC_CODE, 1'b0);
        frame_payload.delete();
        send_frame(TAIL_CODE, TAIL_CODE, 1'b0);
        frame_payload.delete();
        send_frame(HEAD_CODE, 8'h05, 1'b0);
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return HEAD_CODE;
            3: return TAIL_CODE;
            4: return ESC_CODE;
            5: return ESC_HEAD_CODE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_len();
        if ($urandom_range(0, 15) == 0)
            return 8'(MAX_LEN);
        return 8'($urandom_range(0, 6));
    endfunction

    task automatic randomise_slots();
        logic [7:0] t0;
        t0 = pick_type();
        // now and then two slots share a type to exercise the tie rule
        set_slots(t0, pick_len(),
                  $urandom_range(0, 2) == 0 ? t0 : pick_type(), pick_len(),
                  pick_type(), pick_len());
    endtask

    task automatic send_random_frame();
        int         kind;
        int         s;
        int         n;
        logic [7:0] ft;
        kind = $urandom_range(0, 9);
        s    = $urandom_range(0, NUM_SLOTS - 1);
        ft   = slot_type_q[s];
        n    = slot_len_q[s];
        if (kind <= 6) begin
            fill_payload(n);
            send_frame(ft, 8'($urandom), $urandom_range(0, 7) == 0);
        end else if (kind == 7) begin
            // near miss on type or length
            if ($urandom_range(0, 1))
                ft = ft ^ 8'(1 << $urandom_range(0, 7));
            else
                n = (n >= MAX_LEN) ? n - 1 : n + 1;
            fill_payload(n);
            send_frame(ft, 8'($urandom), 1'b0);
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 6)) link_q.push_back(8'($urandom));
            send_link();
        end else begin
            // cut-off frame, the next head restarts
            link_q.push_back(HEAD_CODE);
            repeat ($urandom_range(0, 4)) stuff_byte(8'($urandom));
            send_link();
        end
    endtask

    task automatic test_random_traffic(input int byte_goal, input int beat_goal);
        int byte_start;
        int beat_start;
        byte_start = bytes_sent;
        beat_start = beats_seen;
        while (bytes_sent - byte_start < byte_goal || beats_seen - beat_start < beat_goal) begin
            randomise_slots();
            repeat (6) send_random_frame();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        foreach (slot_type_q[i]) begin
            slot_type_q[i] = 8'h00;
            slot_len_q[i]  = 6'd0;
        end
        foreach (shadow_store[i])
            shadow_store[i] = 8'h00;
        drop_shadow_frame();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_slots();
        test_directed_frames();
        test_input_backpressure();
        test_drain_pause();
        test_slot_priority();
        test_random_traffic(30, 8);

        // last stretch runs flat out on both sides
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        test_random_traffic(10, 2);

        s_tvalid <= 1'b0;
        while (payload_beats_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (error_count == 0)
            $display("PASS escaped_frame_receiver_core");
        else
            $display("FAIL escaped_frame_receiver_core");
        $finish;
    end

endmodule
